FILE: rtl/rrt_pkg.sv
// ----------------------------------------------------------------------------
// RRT* tree insert package
// Shared sizes, codes, sequencer states and the saturating cost add.
// ----------------------------------------------------------------------------
package rrt_pkg;

  localparam int MAX_NODES = 1024;
  localparam int MAX_WALLS = 64;
  localparam int COORD_W   = 16;
  localparam int NODE_W    = $clog2(MAX_NODES);
  localparam int SIZE_W    = NODE_W + 1;
  localparam int WALL_W    = $clog2(MAX_WALLS);
  localparam int WCNT_W    = WALL_W + 1;
  localparam int COST_W    = 24;
  localparam int DIST_W    = 17;
  localparam int SQ_W      = 34;
  localparam int MUL_W     = 18;
  localparam int ACC_W     = 36;
  localparam int CFG_IDX_W = 3;
  localparam int SEG_W     = 4 * COORD_W;

  localparam logic [COST_W-1:0] COST_MAX = '1;
  localparam logic [DIST_W-1:0] DIST_INF = '1;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_WALL   = 2'd1,
    MODE_SAMPLE = 2'd2
  } mode_e;

  typedef enum logic [2:0] {
    ST_ADDED     = 3'd0,
    ST_REJECTED  = 3'd1,
    ST_TREE_FULL = 3'd2,
    ST_WALL_OK   = 3'd3,
    ST_WALL_FULL = 3'd4,
    ST_CLEARED   = 3'd5
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP      = 3'd0,
    CFG_CLEARANCE = 3'd1,
    CFG_RADIUS    = 3'd2,
    CFG_GOAL_X    = 3'd3,
    CFG_GOAL_Y    = 3'd4,
    CFG_GOAL_RAD  = 3'd5,
    CFG_START_X   = 3'd6,
    CFG_START_Y   = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    MS_D2, MS_DOT1, MS_DOT2, MS_LEN, MS_CROSS, MS_STEERX, MS_STEERY
  } mac_sel_e;

  typedef enum logic [5:0] {
    S_IDLE, S_DISPATCH,
    S_NEAR_RD, S_NEAR_LD, S_NEAR_CMP, S_NEAR_SQ,
    S_STEER, S_STEER_XD, S_STEER_XF, S_STEER_YD, S_STEER_YF,
    S_WALL_START, S_WALL_RD, S_WALL_LD, S_WALL_DOT1, S_WALL_DOT2, S_WALL_LEN,
    S_WALL_LQ, S_WALL_CR, S_WALL_DQ, S_WALL_SQ, S_WALL_PQ, S_WALL_CMP,
    S_PAR_START, S_PAR_RD, S_PAR_LD, S_PAR_SQ, S_PAR_CMP, S_PAR_END,
    S_FB_SQ, S_FB_CMP, S_INSERT,
    S_REW_RD, S_REW_LD, S_REW_SQ, S_REW_CMP, S_REW_NEXT,
    S_GOAL, S_GOAL_SQ, S_GOAL_CMP,
    S_MAC0, S_MAC1, S_MAC2, S_SQRT_WAIT, S_DIV_WAIT,
    S_EMIT
  } state_e;

  function automatic logic [COST_W-1:0] sat_add(input logic [DIST_W-1:0] d,
                                                input logic [COST_W-1:0] c);
    logic [COST_W:0] s;
    s = {1'b0, c} + (COST_W+1)'(d);
    return s[COST_W] ? COST_MAX : s[COST_W-1:0];
  endfunction

endpackage

FILE: rtl/rrt_star_tree_insert.sv
// ----------------------------------------------------------------------------
// RRT* tree insert
// Grows an RRT* tree in Q12.4 fixed point with wall clearance checks.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i/in_ready_o) carries one command per transfer:
// clear, append wall segment, or offer sample point. Output channel
// (out_valid_o/out_ready_i) returns one result per command; an undefined
// mode gives none. The user must write configuration registers through
// cfg_we_i/cfg_index_i/cfg_data_i while idle; the block does not enforce it.
// One command is worked at a time; in_ready_o is high only in the idle state.
// A sample visits each node three times (nearest, parent, rewire) through one
// 18x18 multiplier, the bit-serial root unit and, for walls and for steering,
// the bit-serial divider.
// The result sits in an output register; the next command is taken while it
// waits, and a finished result stalls in the emit state until the register
// is free.
// Reset leaves a tree holding only the root at the start registers, no walls
// and no goal node.
// ----------------------------------------------------------------------------
module rrt_star_tree_insert (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    mode_i,
  input  logic [rrt_pkg::COORD_W-1:0]   point_ax_i,
  input  logic [rrt_pkg::COORD_W-1:0]   point_ay_i,
  input  logic [rrt_pkg::COORD_W-1:0]   point_bx_i,
  input  logic [rrt_pkg::COORD_W-1:0]   point_by_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [rrt_pkg::COORD_W-1:0]   node_x_o,
  output logic [rrt_pkg::COORD_W-1:0]   node_y_o,
  output logic [rrt_pkg::NODE_W-1:0]    node_index_o,
  output logic [rrt_pkg::NODE_W-1:0]    parent_index_o,
  output logic [rrt_pkg::COST_W-1:0]    node_cost_o,
  output logic [rrt_pkg::NODE_W-1:0]    rewired_count_o,
  output logic                          path_found_o,
  output logic [rrt_pkg::NODE_W-1:0]    best_goal_index_o,
  output logic [rrt_pkg::DIST_W-1:0]    best_goal_distance_o,
  output logic [rrt_pkg::SIZE_W-1:0]    node_total_o,
  input  logic                          cfg_we_i,
  input  logic [rrt_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rrt_pkg::COORD_W-1:0]   cfg_data_i
);
  import rrt_pkg::*;

  // configuration
  logic [COORD_W-1:0] step_q, clear_q, radius_q, goal_x_q, goal_y_q, goal_rad_q;
  logic [COORD_W-1:0] start_x_q, start_y_q;

  // control
  state_e              state_q, state_d, ret_q;
  mac_sel_e            mac_sel_q;
  logic [SIZE_W-1:0]   tree_size_q, idx_q;
  logic [WCNT_W-1:0]   wall_total_q;
  logic [NODE_W-1:0]   goal_node_q;
  logic [DIST_W-1:0]   goal_best_q;
  logic                goal_reached_q;
  logic [COORD_W-1:0]  root_x_q, root_y_q;
  logic                out_valid_q;

  // command
  logic [1:0]          mode_q;
  logic [COORD_W-1:0]  ax_q, ay_q, bx_q, by_q;
  status_e             status_q;

  // working registers
  logic [COORD_W-1:0]  ux_q, uy_q, vx_q, vy_q, nx_q, ny_q;
  logic [COORD_W-1:0]  near_x_q, near_y_q, wax_q, way_q, wbx_q, wby_q;
  logic [SQ_W-1:0]     best2_q, seg_q, q_q;
  logic [NODE_W-1:0]   near_q, par_q, new_idx_q, rew_q;
  logic [COST_W-1:0]   near_cost_q, cur_cost_q, cost_q;
  logic [DIST_W-1:0]   d_q;
  logic signed [DIST_W-1:0] abx_q, aby_q, acx_q, acy_q;
  logic                found_q;
  logic signed [ACC_W-1:0]  acc_q, prod_q;

  // memories
  logic [COORD_W-1:0]  mem_x [MAX_NODES];
  logic [COORD_W-1:0]  mem_y [MAX_NODES];
  logic [NODE_W-1:0]   mem_par [MAX_NODES];
  logic [COST_W-1:0]   mem_cost [MAX_NODES];
  logic [SEG_W-1:0]    mem_wall [MAX_WALLS];
  logic [COORD_W-1:0]  rd_x_q, rd_y_q;
  logic [COST_W-1:0]   rd_cost_q;
  logic [SEG_W-1:0]    rd_wall_q;

  // outputs
  logic [2:0]          o_status_q;
  logic [COORD_W-1:0]  o_x_q, o_y_q;
  logic [NODE_W-1:0]   o_idx_q, o_par_q, o_rew_q, o_goal_idx_q;
  logic [COST_W-1:0]   o_cost_q;
  logic                o_found_q;
  logic [DIST_W-1:0]   o_goal_dist_q;
  logic [SIZE_W-1:0]   o_total_q;

  // shared units
  logic                sq_start, sq_done, dv_start, dv_done;
  logic [SQ_W-1:0]     sq_rad, dv_num, dv_quot;
  logic [DIST_W-1:0]   sq_root;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [ACC_W-1:0] acc_abs;

  // derived conditions
  logic                in_fire, emit_ok, last_node, last_wall, last_rew;
  logic                near_better, steer_direct, d_in_rad, par_better, rew_better;
  logic                seg_hit, goal_hit;
  logic [COORD_W-1:0]  node_x, node_y;
  logic [COST_W-1:0]   node_cost, pc_par, pc_rew;
  logic [COORD_W-1:0]  w_ax, w_ay, w_bx, w_by;
  logic signed [DIST_W-1:0] dxs, dys, bpx, bpy;
  logic [COORD_W-1:0]  sdx, sdy;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign emit_ok    = !out_valid_q || out_ready_i;

  assign node_x    = (idx_q == '0) ? root_x_q : rd_x_q;
  assign node_y    = (idx_q == '0) ? root_y_q : rd_y_q;
  assign node_cost = (idx_q == '0) ? '0 : rd_cost_q;
  assign {w_by, w_bx, w_ay, w_ax} = rd_wall_q;

  assign last_node    = (idx_q + SIZE_W'(1)) == tree_size_q;
  assign last_wall    = (idx_q + SIZE_W'(1)) == SIZE_W'(wall_total_q);
  assign last_rew     = (idx_q + SIZE_W'(1)) == SIZE_W'(new_idx_q);
  assign near_better  = (idx_q == '0) || (acc_q[SQ_W-1:0] < best2_q);
  assign steer_direct = (d_q < DIST_W'(step_q)) || (d_q == '0);
  assign d_in_rad     = d_q < DIST_W'(radius_q);
  assign pc_par       = sat_add(d_q, cur_cost_q);
  assign pc_rew       = sat_add(d_q, cost_q);
  assign par_better   = !found_q || (pc_par < cost_q);
  assign rew_better   = pc_rew < cur_cost_q;
  assign seg_hit      = seg_q < SQ_W'(clear_q);
  assign goal_hit     = (d_q < DIST_W'(goal_rad_q)) && (d_q < goal_best_q);

  assign acc_abs  = acc_q[ACC_W-1] ? -acc_q : acc_q;
  assign sq_rad   = (state_q == S_NEAR_SQ) ? best2_q : acc_q[SQ_W-1:0];
  assign dv_num   = acc_abs[SQ_W-1:0];

  assign dxs = $signed({1'b0, ux_q}) - $signed({1'b0, vx_q});
  assign dys = $signed({1'b0, uy_q}) - $signed({1'b0, vy_q});
  assign bpx = $signed({1'b0, wbx_q}) - $signed({1'b0, nx_q});
  assign bpy = $signed({1'b0, wby_q}) - $signed({1'b0, ny_q});
  assign sdx = (ax_q >= near_x_q) ? ax_q - near_x_q : near_x_q - ax_q;
  assign sdy = (ay_q >= near_y_q) ? ay_q - near_y_q : near_y_q - ay_q;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (mac_sel_q)
      MS_D2: begin
        mul_a = (state_q == S_MAC1) ? MUL_W'(dys) : MUL_W'(dxs);
        mul_b = mul_a;
      end
      MS_DOT1: begin
        mul_a = (state_q == S_MAC1) ? MUL_W'(aby_q) : MUL_W'(abx_q);
        mul_b = (state_q == S_MAC1) ? MUL_W'(acy_q) : MUL_W'(acx_q);
      end
      MS_DOT2: begin
        mul_a = (state_q == S_MAC1) ? MUL_W'(aby_q) : MUL_W'(abx_q);
        mul_b = (state_q == S_MAC1) ? MUL_W'(bpy) : MUL_W'(bpx);
      end
      MS_LEN: begin
        mul_a = (state_q == S_MAC1) ? MUL_W'(aby_q) : MUL_W'(abx_q);
        mul_b = mul_a;
      end
      MS_CROSS: begin
        mul_a = (state_q == S_MAC1) ? MUL_W'(acy_q) : MUL_W'(acx_q);
        mul_b = (state_q == S_MAC1) ? MUL_W'(abx_q) : MUL_W'(aby_q);
      end
      MS_STEERX: begin
        mul_a = (state_q == S_MAC1) ? '0 : MUL_W'(sdx);
        mul_b = MUL_W'(step_q);
      end
      MS_STEERY: begin
        mul_a = (state_q == S_MAC1) ? '0 : MUL_W'(sdy);
        mul_b = MUL_W'(step_q);
      end
      default: ;
    endcase
  end

  rrt_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (sq_rad),
    .done_o  (sq_done),
    .root_o  (sq_root)
  );

  rrt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (d_q),
    .done_o  (dv_done),
    .quot_o  (dv_quot)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    sq_start = 1'b0;
    dv_start = 1'b0;
    unique case (state_q)
      S_IDLE:     if (in_fire) state_d = S_DISPATCH;
      S_DISPATCH: begin
        case (mode_q)
          MODE_CLEAR, MODE_WALL: state_d = S_EMIT;
          MODE_SAMPLE: state_d = (tree_size_q >= SIZE_W'(MAX_NODES)) ? S_EMIT : S_NEAR_RD;
          default: state_d = S_IDLE;
        endcase
      end
      S_NEAR_RD:  state_d = S_NEAR_LD;
      S_NEAR_LD:  state_d = S_MAC0;
      S_NEAR_CMP: state_d = last_node ? S_NEAR_SQ : S_NEAR_RD;
      S_NEAR_SQ, S_WALL_LEN, S_WALL_SQ, S_PAR_SQ, S_FB_SQ, S_REW_SQ, S_GOAL_SQ: begin
        sq_start = 1'b1;
        state_d  = S_SQRT_WAIT;
      end
      S_STEER_XD, S_STEER_YD, S_WALL_CR: begin
        dv_start = 1'b1;
        state_d  = S_DIV_WAIT;
      end
      S_STEER:      state_d = steer_direct ? S_WALL_START : S_MAC0;
      S_STEER_XF:   state_d = S_MAC0;
      S_STEER_YF:   state_d = S_WALL_START;
      S_WALL_START: state_d = (wall_total_q == '0) ? S_PAR_START : S_WALL_RD;
      S_WALL_RD:    state_d = S_WALL_LD;
      S_WALL_LD, S_WALL_DOT1, S_WALL_DOT2, S_WALL_LQ: state_d = S_MAC0;
      S_WALL_DQ, S_WALL_PQ: state_d = S_WALL_CMP;
      S_WALL_CMP: begin
        if (seg_hit)        state_d = S_EMIT;
        else if (last_wall) state_d = S_PAR_START;
        else                state_d = S_WALL_RD;
      end
      S_PAR_START: state_d = S_PAR_RD;
      S_PAR_RD:    state_d = S_PAR_LD;
      S_PAR_LD:    state_d = S_MAC0;
      S_PAR_CMP:   state_d = last_node ? S_PAR_END : S_PAR_RD;
      S_PAR_END:   state_d = found_q ? S_INSERT : S_MAC0;
      S_FB_CMP:    state_d = S_INSERT;
      S_INSERT:    state_d = S_REW_RD;
      S_REW_RD:    state_d = S_REW_LD;
      S_REW_LD:    state_d = (idx_q[NODE_W-1:0] == par_q) ? S_REW_NEXT : S_MAC0;
      S_REW_CMP:   state_d = S_REW_NEXT;
      S_REW_NEXT:  state_d = last_rew ? S_GOAL : S_REW_RD;
      S_GOAL:      state_d = S_MAC0;
      S_GOAL_CMP:  state_d = S_EMIT;
      S_MAC0:      state_d = S_MAC1;
      S_MAC1:      state_d = S_MAC2;
      S_MAC2:      state_d = ret_q;
      S_SQRT_WAIT: if (sq_done) state_d = ret_q;
      S_DIV_WAIT:  if (dv_done) state_d = ret_q;
      S_EMIT:      if (emit_ok) state_d = S_IDLE;
      default:     state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      out_valid_q    <= 1'b0;
      tree_size_q    <= SIZE_W'(1);
      wall_total_q   <= '0;
      goal_node_q    <= '0;
      goal_best_q    <= DIST_INF;
      goal_reached_q <= 1'b0;
      root_x_q       <= '0;
      root_y_q       <= '0;
      step_q         <= 16'd320;
      clear_q        <= 16'd160;
      radius_q       <= 16'd800;
      goal_x_q       <= '0;
      goal_y_q       <= '0;
      goal_rad_q     <= 16'd320;
      start_x_q      <= '0;
      start_y_q      <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_index_i))
          CFG_STEP:      step_q     <= cfg_data_i;
          CFG_CLEARANCE: clear_q    <= cfg_data_i;
          CFG_RADIUS:    radius_q   <= cfg_data_i;
          CFG_GOAL_X:    goal_x_q   <= cfg_data_i;
          CFG_GOAL_Y:    goal_y_q   <= cfg_data_i;
          CFG_GOAL_RAD:  goal_rad_q <= cfg_data_i;
          CFG_START_X:   start_x_q  <= cfg_data_i;
          CFG_START_Y:   start_y_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      if (state_q == S_EMIT && emit_ok) out_valid_q <= 1'b1;
      if (state_q == S_DISPATCH) begin
        if (mode_q == MODE_CLEAR) begin
          tree_size_q    <= SIZE_W'(1);
          wall_total_q   <= '0;
          goal_node_q    <= '0;
          goal_best_q    <= DIST_INF;
          goal_reached_q <= 1'b0;
          root_x_q       <= start_x_q;
          root_y_q       <= start_y_q;
        end else if (mode_q == MODE_WALL && wall_total_q < WCNT_W'(MAX_WALLS)) begin
          wall_total_q <= wall_total_q + WCNT_W'(1);
        end
      end
      if (state_q == S_INSERT) tree_size_q <= tree_size_q + SIZE_W'(1);
      if (state_q == S_GOAL_CMP && goal_hit) begin
        goal_best_q    <= d_q;
        goal_node_q    <= new_idx_q;
        goal_reached_q <= 1'b1;
      end
    end
  end

  // memories: registered reads at the loop index
  always_ff @(posedge clk_i) begin
    rd_x_q    <= mem_x[idx_q[NODE_W-1:0]];
    rd_y_q    <= mem_y[idx_q[NODE_W-1:0]];
    rd_cost_q <= mem_cost[idx_q[NODE_W-1:0]];
    rd_wall_q <= mem_wall[idx_q[WALL_W-1:0]];
    if (state_q == S_DISPATCH && mode_q == MODE_WALL && wall_total_q < WCNT_W'(MAX_WALLS))
      mem_wall[wall_total_q[WALL_W-1:0]] <= {by_q, bx_q, ay_q, ax_q};
    if (state_q == S_INSERT) begin
      mem_x[tree_size_q[NODE_W-1:0]]    <= nx_q;
      mem_y[tree_size_q[NODE_W-1:0]]    <= ny_q;
      mem_par[tree_size_q[NODE_W-1:0]]  <= par_q;
      mem_cost[tree_size_q[NODE_W-1:0]] <= cost_q;
    end else if (state_q == S_REW_CMP && d_in_rad && rew_better) begin
      mem_par[idx_q[NODE_W-1:0]]  <= new_idx_q;
      mem_cost[idx_q[NODE_W-1:0]] <= pc_rew;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    prod_q <= ACC_W'(mul_a * mul_b);
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          mode_q <= mode_i;
          ax_q   <= point_ax_i;
          ay_q   <= point_ay_i;
          bx_q   <= point_bx_i;
          by_q   <= point_by_i;
        end
      end
      S_DISPATCH: begin
        idx_q <= '0;
        case (mode_q)
          MODE_CLEAR:  status_q <= ST_CLEARED;
          MODE_WALL:   status_q <= (wall_total_q < WCNT_W'(MAX_WALLS)) ? ST_WALL_OK
                                                                        : ST_WALL_FULL;
          default:     status_q <= ST_TREE_FULL;
        endcase
      end
      S_NEAR_LD, S_PAR_LD, S_REW_LD: begin
        ux_q       <= node_x;
        uy_q       <= node_y;
        vx_q       <= (state_q == S_NEAR_LD) ? ax_q : nx_q;
        vy_q       <= (state_q == S_NEAR_LD) ? ay_q : ny_q;
        cur_cost_q <= node_cost;
        mac_sel_q  <= MS_D2;
        ret_q      <= (state_q == S_NEAR_LD) ? S_NEAR_CMP :
                      (state_q == S_PAR_LD)  ? S_PAR_SQ : S_REW_SQ;
      end
      S_NEAR_CMP: begin
        if (near_better) begin
          best2_q     <= acc_q[SQ_W-1:0];
          near_q      <= idx_q[NODE_W-1:0];
          near_x_q    <= ux_q;
          near_y_q    <= uy_q;
          near_cost_q <= cur_cost_q;
        end
        idx_q <= idx_q + SIZE_W'(1);
      end
      S_NEAR_SQ:  ret_q <= S_STEER;
      S_WALL_LEN: ret_q <= S_WALL_LQ;
      S_WALL_SQ:  ret_q <= S_WALL_PQ;
      S_PAR_SQ:   ret_q <= S_PAR_CMP;
      S_FB_SQ:    ret_q <= S_FB_CMP;
      S_REW_SQ:   ret_q <= S_REW_CMP;
      S_GOAL_SQ:  ret_q <= S_GOAL_CMP;
      S_STEER_XD: ret_q <= S_STEER_XF;
      S_STEER_YD: ret_q <= S_STEER_YF;
      S_WALL_CR:  ret_q <= S_WALL_DQ;
      S_STEER: begin
        nx_q      <= ax_q;
        ny_q      <= ay_q;
        mac_sel_q <= MS_STEERX;
        ret_q     <= S_STEER_XD;
      end
      S_STEER_XF: begin
        nx_q      <= (ax_q >= near_x_q) ? near_x_q + q_q[COORD_W-1:0]
                                        : near_x_q - q_q[COORD_W-1:0];
        mac_sel_q <= MS_STEERY;
        ret_q     <= S_STEER_YD;
      end
      S_STEER_YF: begin
        ny_q <= (ay_q >= near_y_q) ? near_y_q + q_q[COORD_W-1:0]
                                   : near_y_q - q_q[COORD_W-1:0];
      end
      S_WALL_START: idx_q <= '0;
      S_WALL_LD: begin
        wax_q <= w_ax;
        way_q <= w_ay;
        wbx_q <= w_bx;
        wby_q <= w_by;
        abx_q <= $signed({1'b0, w_bx}) - $signed({1'b0, w_ax});
        aby_q <= $signed({1'b0, w_by}) - $signed({1'b0, w_ay});
        acx_q <= $signed({1'b0, nx_q}) - $signed({1'b0, w_ax});
        acy_q <= $signed({1'b0, ny_q}) - $signed({1'b0, w_ay});
        ux_q  <= w_ax;
        uy_q  <= w_ay;
        vx_q  <= nx_q;
        vy_q  <= ny_q;
        if (w_ax == w_bx && w_ay == w_by) begin
          mac_sel_q <= MS_D2;
          ret_q     <= S_WALL_SQ;
        end else begin
          mac_sel_q <= MS_DOT1;
          ret_q     <= S_WALL_DOT1;
        end
      end
      S_WALL_DOT1: begin
        mac_sel_q <= acc_q[ACC_W-1] ? MS_D2 : MS_DOT2;
        ret_q     <= acc_q[ACC_W-1] ? S_WALL_SQ : S_WALL_DOT2;
      end
      S_WALL_DOT2: begin
        // past the far end: distance to the end point
        if (acc_q[ACC_W-1]) begin
          ux_q      <= wbx_q;
          uy_q      <= wby_q;
          mac_sel_q <= MS_D2;
          ret_q     <= S_WALL_SQ;
        end else begin
          mac_sel_q <= MS_LEN;
          ret_q     <= S_WALL_LEN;
        end
      end
      S_WALL_LQ: begin
        mac_sel_q <= MS_CROSS;
        ret_q     <= S_WALL_CR;
      end
      S_WALL_DQ: seg_q <= q_q;
      S_WALL_PQ: seg_q <= SQ_W'(d_q);
      S_WALL_CMP: begin
        if (seg_hit) status_q <= ST_REJECTED;
        idx_q <= idx_q + SIZE_W'(1);
      end
      S_PAR_START: begin
        idx_q   <= '0;
        found_q <= 1'b0;
      end
      S_PAR_CMP: begin
        if (d_in_rad && par_better) begin
          cost_q  <= pc_par;
          par_q   <= idx_q[NODE_W-1:0];
          found_q <= 1'b1;
        end
        idx_q <= idx_q + SIZE_W'(1);
      end
      S_PAR_END: begin
        if (!found_q) begin
          par_q     <= near_q;
          ux_q      <= near_x_q;
          uy_q      <= near_y_q;
          vx_q      <= nx_q;
          vy_q      <= ny_q;
          mac_sel_q <= MS_D2;
          ret_q     <= S_FB_SQ;
        end
      end
      S_FB_CMP: cost_q <= sat_add(d_q, near_cost_q);
      S_INSERT: begin
        new_idx_q <= tree_size_q[NODE_W-1:0];
        idx_q     <= '0;
        rew_q     <= '0;
      end
      S_REW_CMP: if (d_in_rad && rew_better) rew_q <= rew_q + NODE_W'(1);
      S_REW_NEXT: idx_q <= idx_q + SIZE_W'(1);
      S_GOAL: begin
        ux_q      <= nx_q;
        uy_q      <= ny_q;
        vx_q      <= goal_x_q;
        vy_q      <= goal_y_q;
        mac_sel_q <= MS_D2;
        ret_q     <= S_GOAL_SQ;
      end
      S_GOAL_CMP: status_q <= ST_ADDED;
      S_MAC1: acc_q <= prod_q;
      S_MAC2: acc_q <= (mac_sel_q == MS_CROSS) ? acc_q - prod_q : acc_q + prod_q;
      S_SQRT_WAIT: if (sq_done) d_q <= sq_root;
      S_DIV_WAIT:  if (dv_done) q_q <= dv_quot;
      S_EMIT: begin
        if (emit_ok) begin
          o_status_q    <= status_q;
          o_x_q         <= (status_q == ST_ADDED || status_q == ST_REJECTED) ? nx_q : '0;
          o_y_q         <= (status_q == ST_ADDED || status_q == ST_REJECTED) ? ny_q : '0;
          o_idx_q       <= (status_q == ST_ADDED) ? new_idx_q : '0;
          o_par_q       <= (status_q == ST_ADDED) ? par_q : '0;
          o_cost_q      <= (status_q == ST_ADDED) ? cost_q : '0;
          o_rew_q       <= (status_q == ST_ADDED) ? rew_q : '0;
          o_found_q     <= goal_reached_q;
          o_goal_idx_q  <= goal_node_q;
          o_goal_dist_q <= goal_best_q;
          o_total_q     <= tree_size_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = o_status_q;
  assign node_x_o             = o_x_q;
  assign node_y_o             = o_y_q;
  assign node_index_o         = o_idx_q;
  assign parent_index_o       = o_par_q;
  assign node_cost_o          = o_cost_q;
  assign rewired_count_o      = o_rew_q;
  assign path_found_o         = o_found_q;
  assign best_goal_index_o    = o_goal_idx_q;
  assign best_goal_distance_o = o_goal_dist_q;
  assign node_total_o         = o_total_q;

  `ifndef SYNTHESIS
  a_size_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tree_size_q != '0 && tree_size_q <= SIZE_W'(MAX_NODES))
    else $error("tree size out of range");
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_INSERT |-> tree_size_q < SIZE_W'(MAX_NODES))
    else $error("insert into full tree");
  a_wall_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wall_total_q <= WCNT_W'(MAX_WALLS)) else $error("wall count out of range");
  a_emit_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && emit_ok) |=> out_valid_q && state_q == S_IDLE)
    else $error("result not loaded");
  a_goal_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !goal_reached_q |-> goal_best_q == DIST_INF) else $error("goal tracking mismatch");
  `endif

endmodule

FILE: rtl/rrt_isqrt.sv
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floor root of a 34-bit value, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module rrt_isqrt (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [rrt_pkg::SQ_W-1:0]  rad_i,
  output logic                      done_o,
  output logic [rrt_pkg::DIST_W-1:0] root_o
);
  import rrt_pkg::*;

  logic [SQ_W-1:0]   rad_q;
  logic [DIST_W:0]   rem_q;
  logic [DIST_W-1:0] root_q;
  logic [4:0]        cnt_q;
  logic              busy_q, done_q;
  logic [DIST_W+2:0] rem_t, trial;

  assign rem_t  = {rem_q, rad_q[SQ_W-1:SQ_W-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign done_o = done_q;
  assign root_o = root_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'(DIST_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 5'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= rad_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q <= {rad_q[SQ_W-3:0], 2'b00};
      if (rem_t >= trial) begin
        rem_q  <= (DIST_W+1)'(rem_t - trial);
        root_q <= {root_q[DIST_W-2:0], 1'b1};
      end else begin
        rem_q  <= rem_t[DIST_W:0];
        root_q <= {root_q[DIST_W-2:0], 1'b0};
      end
    end
  end

  `ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("root unit restarted while busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |=> !done_q) else $error("root done held");
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("root done without work");
  `endif

endmodule

FILE: rtl/rrt_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring unsigned division, 34-bit dividend by 17-bit divisor.
// ----------------------------------------------------------------------------
module rrt_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rrt_pkg::SQ_W-1:0]   num_i,
  input  logic [rrt_pkg::DIST_W-1:0] den_i,
  output logic                       done_o,
  output logic [rrt_pkg::SQ_W-1:0]   quot_o
);
  import rrt_pkg::*;

  logic [SQ_W-1:0]   num_q;
  logic [DIST_W-1:0] den_q, rem_q;
  logic [5:0]        cnt_q;
  logic              busy_q, done_q;
  logic [DIST_W:0]   rem_t;

  assign rem_t  = {rem_q, num_q[SQ_W-1]};
  assign done_o = done_q;
  assign quot_o = num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(SQ_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // quotient bits shift in where dividend bits leave
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (busy_q) begin
      if (rem_t >= {1'b0, den_q}) begin
        rem_q <= DIST_W'(rem_t - {1'b0, den_q});
        num_q <= {num_q[SQ_W-2:0], 1'b1};
      end else begin
        rem_q <= rem_t[DIST_W-1:0];
        num_q <= {num_q[SQ_W-2:0], 1'b0};
      end
    end
  end

  `ifndef SYNTHESIS
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_den_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> den_i != '0) else $error("divide by zero");
  a_done_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q)) else $error("divider done without work");
  `endif

endmodule
